// ===== rtl/core/twwa_pkg.sv =====
// ----------------------------------------------------------------------------
// twwa_pkg
// shared types, constants and codes of the time weighted window averager
// ----------------------------------------------------------------------------
`default_nettype none

package twwa_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int TIME_W  = 32;
    localparam int RATE_W  = 16;
    localparam int ENTRY_W = TIME_W + RATE_W + 1;
    localparam int ACC_W   = TIME_W + RATE_W + 1;
    localparam int DUR_W   = TIME_W + 1;
    localparam int FRAC_W  = 17;
    localparam int QUOT_W  = 16;
    localparam int DCNT_W  = $clog2(QUOT_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_START     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RELAXED   = 2'd3;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic [RATE_W:0]   ONE_BPM  = 17'd256;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_STOP   = 2'd1,
        ACT_RECORD = 2'd2,
        ACT_QUERY  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REC_RD,
        ST_REC_CHK,
        ST_REC_WR,
        ST_PR_RD,
        ST_PR_CHK,
        ST_Q_RD,
        ST_Q_CHK,
        ST_WALK,
        ST_FLUSH,
        ST_DRAIN,
        ST_COV,
        ST_COV_WAIT,
        ST_MUL_TOP,
        ST_MUL_DEN,
        ST_SC_INIT,
        ST_SC_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_STOP,
        OP_RD_LAST,
        OP_REC_WR,
        OP_RD_SECOND,
        OP_DROP,
        OP_LAST_CAP,
        OP_WALK,
        OP_FLUSH,
        OP_COV_INIT,
        OP_MUL_TOP,
        OP_MUL_DEN,
        OP_SC_INIT,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    rec_allowed;
        logic    running;
        logic    count_zero;
        logic    count_gt1;
        logic    rec_ok;
        logic    prune_hit;
        logic    last_future;
        logic    walk_done;
        logic    pipe_busy;
        logic    div_busy;
        logic    score_ok;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/twwa_ram.sv =====
// ----------------------------------------------------------------------------
// twwa_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module twwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/twwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// twwa_ctrl
// sequencer for start, stop, record, prune, window walk and the two divisions
// ----------------------------------------------------------------------------
`default_nettype none

module twwa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire twwa_pkg::t_status i_status,
    output twwa_pkg::t_cmd        o_cmd
);
    import twwa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        busy     = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.action)
                    ACT_START: begin
                        o_cmd.op = OP_START;
                        n_state  = ST_DONE;
                    end
                    ACT_STOP: begin
                        o_cmd.op = OP_STOP;
                        n_state  = ST_DONE;
                    end
                    ACT_RECORD: begin
                        if (!i_status.rec_allowed) begin
                            n_state = ST_DONE;
                        end else if (i_status.count_zero) begin
                            n_state = ST_REC_WR;
                        end else begin
                            n_state = ST_REC_RD;
                        end
                    end
                    default: begin
                        n_state = i_status.running ? ST_PR_RD : ST_DONE;
                    end
                endcase
            end
            ST_REC_RD: begin
                o_cmd.op = OP_RD_LAST;
                n_state  = ST_REC_CHK;
            end
            ST_REC_CHK: begin
                n_state = i_status.rec_ok ? ST_REC_WR : ST_DONE;
            end
            ST_REC_WR: begin
                o_cmd.op = OP_REC_WR;
                n_state  = ST_PR_RD;
            end
            ST_PR_RD: begin
                if (i_status.count_gt1) begin
                    o_cmd.op = OP_RD_SECOND;
                    n_state  = ST_PR_CHK;
                end else if (i_status.action == ACT_QUERY && !i_status.count_zero) begin
                    n_state = ST_Q_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PR_CHK: begin
                if (i_status.prune_hit) begin
                    o_cmd.op = OP_DROP;
                    n_state  = ST_PR_RD;
                end else if (i_status.action == ACT_QUERY) begin
                    n_state = ST_Q_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_Q_RD: begin
                o_cmd.op = OP_RD_LAST;
                n_state  = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                o_cmd.op = OP_LAST_CAP;
                n_state  = i_status.last_future ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                o_cmd.op = OP_WALK;
                if (i_status.walk_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.op = OP_FLUSH;
                n_state  = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_COV;
                end
            end
            ST_COV: begin
                o_cmd.op = OP_COV_INIT;
                n_state  = ST_COV_WAIT;
            end
            ST_COV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = i_status.score_ok ? ST_MUL_TOP : ST_DONE;
                end
            end
            ST_MUL_TOP: begin
                o_cmd.op = OP_MUL_TOP;
                n_state  = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                o_cmd.op = OP_MUL_DEN;
                n_state  = ST_SC_INIT;
            end
            ST_SC_INIT: begin
                o_cmd.op = OP_SC_INIT;
                n_state  = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.op = OP_DONE;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/twwa_datapath.sv =====
// ----------------------------------------------------------------------------
// twwa_datapath
// sample store, window walk pipeline, multiplier and shared divider
// ----------------------------------------------------------------------------
`default_nettype none

module twwa_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [twwa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [twwa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic [1:0]                          i_action,
    input  wire logic [twwa_pkg::TIME_W-1:0]         i_now,
    input  wire logic [twwa_pkg::TIME_W-1:0]         i_sample_time,
    input  wire logic                                i_sample_available,
    input  wire logic [twwa_pkg::RATE_W-1:0]         i_sample_value,
    input  wire twwa_pkg::t_cmd                      i_cmd,
    output twwa_pkg::t_status                        o_status,
    output logic                                     o_done,
    output logic                                     o_session_running,
    output logic                                     o_score_available,
    output logic [twwa_pkg::FRAC_W-1:0]              o_score,
    output logic [twwa_pkg::FRAC_W-1:0]              o_coverage
);
    import twwa_pkg::*;

    // configuration
    logic [TIME_W-1:0] r_wl, r_max_age;
    logic [RATE_W-1:0] r_ref_start, r_ref_relaxed;

    // latched item
    t_action           r_action;
    logic [TIME_W-1:0] r_now, r_stime;
    logic              r_savail;
    logic [RATE_W-1:0] r_sval;

    // store control and session
    logic [ADDR_W-1:0] r_oldest;
    logic [CNT_W-1:0]  r_count;
    logic              r_active;
    logic [TIME_W-1:0] r_sstart;

    // ram
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [TIME_W-1:0] rd_time;
    logic [RATE_W-1:0] rd_val;
    logic              rd_vld;

    // walk
    logic              r_last_vld;
    logic [TIME_W-1:0] r_last_time;
    logic [CNT_W-1:0]  r_idx;
    logic              r_rd_v, r_have_cur;
    logic [TIME_W-1:0] r_cur_time;
    logic [RATE_W-1:0] r_cur_val;
    logic              r_cur_vld;
    logic              r_s1_v, r_s2_v;
    logic [TIME_W-1:0] r_dt, r_dt2;
    logic [RATE_W-1:0] r_val;
    logic [ACC_W-1:0]  r_prod, r_total, r_top;
    logic [DUR_W-1:0]  r_dur;

    // divider
    logic [ACC_W-1:0]  r_rem, r_dvs;
    logic [QUOT_W-1:0] r_quot;
    logic [DCNT_W-1:0] r_div_cnt;
    logic              r_div_busy, r_div_score;

    // results
    logic              r_avail;
    logic [FRAC_W-1:0] r_score, r_cov;

    logic running, calibrated, full;
    logic [RATE_W-1:0] span;

    assign running    = r_active && (r_now >= r_sstart);
    assign calibrated = (r_ref_relaxed != '0) &&
                        ({1'b0, r_ref_start} >= ({1'b0, r_ref_relaxed} + ONE_BPM));
    assign span       = r_ref_start - r_ref_relaxed;
    assign full       = (r_count == CNT_W'(STORE_DEPTH));

    assign rd_time = ram_rdata[TIME_W-1:0];
    assign rd_val  = ram_rdata[TIME_W +: RATE_W];
    assign rd_vld  = ram_rdata[ENTRY_W-1];

    // config and latched item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl          <= 32'd30000;
            r_max_age     <= 32'd15000;
            r_ref_start   <= '0;
            r_ref_relaxed <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_wl          <= i_cfg_data;
                CFG_MAX_AGE:       r_max_age     <= i_cfg_data;
                CFG_REF_START:     r_ref_start   <= i_cfg_data[RATE_W-1:0];
                default:           r_ref_relaxed <= i_cfg_data[RATE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_action <= t_action'(i_action);
            r_now    <= i_now;
            r_stime  <= i_sample_time;
            r_savail <= i_sample_available;
            r_sval   <= i_sample_value;
        end
    end

    // record: freshness and stored time
    logic              fresh, s_valid;
    logic [TIME_W-1:0] s_time;

    assign fresh   = (r_stime >= r_sstart) && (r_stime <= r_now) &&
                     ((r_now - r_stime) < r_max_age);
    assign s_valid = r_savail && fresh && (r_sval != '0);
    assign s_time  = (fresh && r_savail) ? r_stime : r_now;

    assign ram_we    = (i_cmd.op == OP_REC_WR);
    assign ram_waddr = r_oldest + r_count[ADDR_W-1:0];
    assign ram_wdata = {s_valid, (s_valid ? r_sval : RATE_W'(0)), s_time};

    always_comb begin
        unique case (i_cmd.op)
            OP_RD_LAST:   ram_raddr = r_oldest + (r_count[ADDR_W-1:0] - ADDR_W'(1));
            OP_RD_SECOND: ram_raddr = r_oldest + ADDR_W'(1);
            default:      ram_raddr = r_oldest + r_idx[ADDR_W-1:0];
        endcase
    end

    twwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // store pointers and session
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_active <= 1'b0;
            r_sstart <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_REF_START ||
                                  i_cfg_idx == CFG_REF_RELAXED)) begin
            r_oldest <= '0;
            r_count  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_START: begin
                    r_active <= 1'b1;
                    r_sstart <= r_now;
                    r_oldest <= '0;
                    r_count  <= '0;
                end
                OP_STOP: begin
                    r_active <= 1'b0;
                    r_oldest <= '0;
                    r_count  <= '0;
                end
                OP_REC_WR: begin
                    if (full) begin
                        r_oldest <= r_oldest + ADDR_W'(1);
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                OP_DROP: begin
                    r_oldest <= r_oldest + ADDR_W'(1);
                    r_count  <= r_count - CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // window walk: interval of one held sample
    logic              proc_v, proc_next;
    logic [TIME_W-1:0] lower, end0, seg_end, seg_begin, b0, n_dt;
    logic [DUR_W-1:0]  tmax;

    assign proc_next = r_rd_v && r_have_cur;
    assign proc_v    = proc_next || ((i_cmd.op == OP_FLUSH) && r_have_cur && !r_rd_v);
    assign lower     = (r_now >= r_wl) ? (r_now - r_wl) : '0;
    assign end0      = (proc_next && rd_time < r_now) ? rd_time : r_now;
    assign tmax      = {1'b0, r_cur_time} + {1'b0, r_max_age};
    assign seg_end   = (tmax < {1'b0, end0}) ? tmax[TIME_W-1:0] : end0;
    assign b0        = (r_sstart > r_cur_time) ? r_sstart : r_cur_time;
    assign seg_begin = (lower > b0) ? lower : b0;
    assign n_dt      = (r_cur_vld && seg_end > seg_begin) ? (seg_end - seg_begin) : '0;

    // shared multiplier
    logic [RATE_W-1:0] mul_a;
    logic [DUR_W-1:0]  mul_b;
    logic [ACC_W-1:0]  mul_p;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_TOP: begin
                mul_a = r_ref_start;
                mul_b = r_dur;
            end
            OP_MUL_DEN: begin
                mul_a = span;
                mul_b = r_dur;
            end
            default: begin
                mul_a = r_val;
                mul_b = DUR_W'(r_dt);
            end
        endcase
    end
    assign mul_p = ACC_W'(mul_a) * ACC_W'(mul_b);

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_p;
        r_dt2   <= r_dt;
        if (i_cmd.op == OP_MUL_DEN) begin
            r_top <= r_prod;
        end
        if (proc_v) begin
            r_dt  <= n_dt;
            r_val <= r_cur_val;
        end
        if (r_rd_v) begin
            r_cur_time <= rd_time;
            r_cur_val  <= rd_val;
            r_cur_vld  <= rd_vld;
        end
        if (i_cmd.op == OP_LAST_CAP) begin
            r_last_vld  <= rd_vld;
            r_last_time <= rd_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v     <= 1'b0;
            r_have_cur <= 1'b0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_idx      <= '0;
            r_total    <= '0;
            r_dur      <= '0;
        end else begin
            r_s1_v <= proc_v;
            r_s2_v <= r_s1_v;
            r_rd_v <= 1'b0;
            if (i_cmd.op == OP_LAST_CAP) begin
                r_idx      <= '0;
                r_have_cur <= 1'b0;
                r_total    <= '0;
                r_dur      <= '0;
            end else begin
                if (i_cmd.op == OP_WALK && r_idx < r_count) begin
                    r_rd_v <= 1'b1;
                    r_idx  <= r_idx + CNT_W'(1);
                end
                if (r_rd_v) begin
                    r_have_cur <= 1'b1;
                end else if (proc_v) begin
                    r_have_cur <= 1'b0;
                end
                if (r_s2_v) begin
                    r_total <= r_total + r_prod;
                    r_dur   <= r_dur + DUR_W'(r_dt2);
                end
            end
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [ACC_W:0]   div_sh;
    logic             div_ge;
    logic [ACC_W-1:0] diff;

    assign div_sh = {r_rem, 1'b0};
    assign div_ge = (div_sh >= {1'b0, r_dvs});
    assign diff   = r_top - r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy  <= 1'b0;
            r_div_score <= 1'b0;
            r_div_cnt   <= '0;
            r_avail     <= 1'b0;
            r_score     <= '0;
            r_cov       <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_avail <= 1'b0;
                    r_score <= '0;
                    r_cov   <= '0;
                end
                OP_COV_INIT: begin
                    if (r_wl == '0) begin
                        r_cov <= '0;
                    end else if (r_dur >= {1'b0, r_wl}) begin
                        r_cov <= FRAC_ONE;
                    end else begin
                        r_rem       <= ACC_W'(r_dur);
                        r_dvs       <= ACC_W'(r_wl);
                        r_div_busy  <= 1'b1;
                        r_div_score <= 1'b0;
                        r_div_cnt   <= '0;
                    end
                end
                OP_SC_INIT: begin
                    r_avail <= 1'b1;
                    if (r_top <= r_total) begin
                        r_score <= '0;
                    end else if (diff >= r_prod) begin
                        r_score <= FRAC_ONE;
                    end else begin
                        r_rem       <= diff;
                        r_dvs       <= r_prod;
                        r_div_busy  <= 1'b1;
                        r_div_score <= 1'b1;
                        r_div_cnt   <= '0;
                    end
                end
                default: begin
                    if (r_div_busy) begin
                        r_rem     <= div_ge ? ACC_W'(div_sh - {1'b0, r_dvs})
                                            : div_sh[ACC_W-1:0];
                        r_quot    <= {r_quot[QUOT_W-2:0], div_ge};
                        r_div_cnt <= r_div_cnt + DCNT_W'(1);
                        if (r_div_cnt == DCNT_W'(QUOT_W - 1)) begin
                            r_div_busy <= 1'b0;
                            if (r_div_score) begin
                                r_score <= FRAC_W'({r_quot[QUOT_W-2:0], div_ge});
                            end else begin
                                r_cov <= FRAC_W'({r_quot[QUOT_W-2:0], div_ge});
                            end
                        end
                    end
                end
            endcase
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (i_cmd.op == OP_DONE);
        end
        if (i_cmd.op == OP_DONE) begin
            o_session_running <= running;
            o_score_available <= r_avail;
            o_score           <= r_score;
            o_coverage        <= r_cov;
        end
    end

    // status
    assign o_status.action      = r_action;
    assign o_status.rec_allowed = calibrated && running;
    assign o_status.running     = running;
    assign o_status.count_zero  = (r_count == '0);
    assign o_status.count_gt1   = (r_count > CNT_W'(1));
    assign o_status.rec_ok      = !((r_now <= rd_time) || (r_savail && r_stime <= rd_time));
    assign o_status.prune_hit   = ({1'b0, rd_time} + {1'b0, r_wl}) <= {1'b0, r_now};
    assign o_status.last_future = (rd_time > r_now);
    assign o_status.walk_done   = (r_idx == r_count) && !r_rd_v;
    assign o_status.pipe_busy   = r_rd_v || r_s1_v || r_s2_v;
    assign o_status.div_busy    = r_div_busy;
    assign o_status.score_ok    = (r_wl != '0) && (r_dur != '0) && r_last_vld &&
                                  ((r_now - r_last_time) < r_max_age) &&
                                  ({r_dur, 1'b0} >= (DUR_W + 1)'(r_wl)) && calibrated;

endmodule

`default_nettype wire

// ===== rtl/core/time_weighted_window_averager.sv =====
// ----------------------------------------------------------------------------
// time_weighted_window_averager
// time weighted sliding window mean of a slow rate sensor, relaxation score
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; each item gives one
// result, shown for exactly one cycle with o_done high, and the receiver
// cannot hold it off. the block works on one item at a time. a record
// prunes the store after it writes a sample, and a query in a running
// session prunes it and then walks the window over the stored samples left
// after pruning, up to 64. the window walk reads one stored sample per
// cycle from the single read port of the sample ram, and each of the two
// divisions takes 16 quotient steps on the shared divider. configuration
// writes are taken any time the block is idle; writing either reference
// rate empties the sample store
// ----------------------------------------------------------------------------
`default_nettype none

module time_weighted_window_averager (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [twwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [twwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command side
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_action,
    input  wire logic [twwa_pkg::TIME_W-1:0]     i_now,
    input  wire logic [twwa_pkg::TIME_W-1:0]     i_sample_time,
    input  wire logic                            i_sample_available,
    input  wire logic [twwa_pkg::RATE_W-1:0]     i_sample_value,
    // result side, one cycle strobe
    output logic                                 o_done,
    output logic                                 o_session_running,
    output logic                                 o_score_available,
    output logic [twwa_pkg::FRAC_W-1:0]          o_score,
    output logic [twwa_pkg::FRAC_W-1:0]          o_coverage
);
    import twwa_pkg::*;

    // command from sequencer, status back from datapath
    t_cmd    cmd;
    t_status status;

    twwa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // store, walk pipeline, multiplier, divider and result registers
    twwa_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_action           (i_action),
        .i_now              (i_now),
        .i_sample_time      (i_sample_time),
        .i_sample_available (i_sample_available),
        .i_sample_value     (i_sample_value),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_done             (o_done),
        .o_session_running  (o_session_running),
        .o_score_available  (o_score_available),
        .o_score            (o_score),
        .o_coverage         (o_coverage)
    );

endmodule

`default_nettype wire

// ===== test/twwa_score_checker.sv =====
// ----------------------------------------------------------------------------
// twwa_score_checker
// watches the configuration, command and result ports of the averager,
// predicts each result from its own copy of the store and compares
// ----------------------------------------------------------------------------
`default_nettype none

module twwa_score_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [twwa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [twwa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_start,
    input  wire logic                            i_busy,
    input  wire logic [1:0]                      i_action,
    input  wire logic [twwa_pkg::TIME_W-1:0]     i_now,
    input  wire logic [twwa_pkg::TIME_W-1:0]     i_sample_time,
    input  wire logic                            i_sample_available,
    input  wire logic [twwa_pkg::RATE_W-1:0]     i_sample_value,
    input  wire logic                            i_done,
    input  wire logic                            i_session_running,
    input  wire logic                            i_score_available,
    input  wire logic [twwa_pkg::FRAC_W-1:0]     i_score,
    input  wire logic [twwa_pkg::FRAC_W-1:0]     i_coverage,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import twwa_pkg::*;

    localparam int EXP_DEPTH = 16;
    localparam int EXP_PTR_W = $clog2(EXP_DEPTH);

    typedef struct packed {
        logic              running;
        logic              avail;
        logic [FRAC_W-1:0] score;
        logic [FRAC_W-1:0] cov;
    } t_score_result;

    // expected results in order of the command transfers
    t_score_result        exp_mem [EXP_DEPTH];
    logic [EXP_PTR_W-1:0] exp_wr, exp_rd;
    int                   exp_cnt;

    logic [TIME_W-1:0] win_len, age_cap;
    logic [RATE_W-1:0] rate_start, rate_relaxed;
    logic [TIME_W-1:0] st_time [STORE_DEPTH];
    logic [RATE_W-1:0] st_rate [STORE_DEPTH];
    logic              st_ok   [STORE_DEPTH];
    logic [ADDR_W-1:0] head;
    int                fill;
    logic              sess_on;
    logic [TIME_W-1:0] sess_t0;

    function automatic logic [ADDR_W-1:0] slot(input int k);
        return head + ADDR_W'(k);
    endfunction

    function automatic logic is_calibrated();
        return rate_relaxed != 0 && {1'b0, rate_start} >= {1'b0, rate_relaxed} + 17'd256;
    endfunction

    function automatic logic is_running(input logic [TIME_W-1:0] now);
        return sess_on && now >= sess_t0;
    endfunction

    task automatic drop_oldest();
        head = head + ADDR_W'(1);
        fill--;
    endtask

    task automatic prune_window(input logic [TIME_W-1:0] now);
        while (fill > 1 && 64'(st_time[slot(1)]) + 64'(win_len) <= 64'(now))
            drop_oldest();
    endtask

    task automatic store_sample(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] ts,
                                input logic av, input logic [RATE_W-1:0] val);
        logic [TIME_W-1:0] last;
        logic              fresh, good;
        logic [ADDR_W-1:0] s;
        if (!is_calibrated() || !is_running(now))
            return;
        if (fill > 0) begin
            last = st_time[slot(fill - 1)];
            if (now <= last || (av && ts <= last))
                return;
        end
        fresh = ts >= sess_t0 && ts <= now && (now - ts) < age_cap;
        good  = av && fresh && val != 0;
        if (!fresh || !av)
            ts = now;
        if (fill >= STORE_DEPTH)
            drop_oldest();
        s = slot(fill);
        st_time[s] = ts;
        st_rate[s] = good ? val : '0;
        st_ok[s]   = good;
        fill++;
        prune_window(now);
    endtask

    // time weighted mean over the window, coverage and relaxation score
    task automatic query_window(input logic [TIME_W-1:0] now, inout t_score_result r);
        logic [63:0]       total, dur, lower, t, stop_t, begin_t, dt, c, span, denom, top, q;
        logic [ADDR_W-1:0] ls, s;
        total = 0;
        dur   = 0;
        if (!is_running(now))
            return;
        prune_window(now);
        if (fill == 0)
            return;
        ls = slot(fill - 1);
        if (st_time[ls] > now)
            return;
        lower = now >= win_len ? 64'(now - win_len) : 64'd0;
        for (int i = 0; i < fill; i++) begin
            s = slot(i);
            if (st_ok[s]) begin
                t      = 64'(st_time[s]);
                stop_t = 64'(now);
                if (i + 1 < fill && 64'(st_time[slot(i + 1)]) < stop_t)
                    stop_t = 64'(st_time[slot(i + 1)]);
                if (t + 64'(age_cap) < stop_t)
                    stop_t = t + 64'(age_cap);
                begin_t = t;
                if (64'(sess_t0) > begin_t) begin_t = 64'(sess_t0);
                if (lower > begin_t) begin_t = lower;
                dt     = stop_t > begin_t ? stop_t - begin_t : 64'd0;
                total += 64'(st_rate[s]) * dt;
                dur   += dt;
            end
        end
        if (win_len != 0) begin
            c     = (dur << 16) / 64'(win_len);
            r.cov = c > 64'd65536 ? FRAC_ONE : c[FRAC_W-1:0];
        end
        if (win_len == 0 || dur == 0 || !st_ok[ls] || (now - st_time[ls]) >= age_cap ||
            2 * dur < 64'(win_len) || !is_calibrated())
            return;
        span  = 64'(rate_start - rate_relaxed);
        denom = dur * span;
        top   = 64'(rate_start) * dur;
        r.avail = 1'b1;
        if (top <= total) begin
            r.score = '0;
        end else if (top - total >= denom) begin
            r.score = FRAC_ONE;
        end else begin
            q       = ((top - total) << 16) / denom;
            r.score = q[FRAC_W-1:0];
        end
    endtask

    task automatic predict_window_result(input t_action act, input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] ts, input logic av,
                                         input logic [RATE_W-1:0] val);
        t_score_result r;
        r = '0;
        case (act)
            ACT_START: begin
                sess_on = 1'b1;
                sess_t0 = now;
                head    = '0;
                fill    = 0;
            end
            ACT_STOP: begin
                sess_on = 1'b0;
                head    = '0;
                fill    = 0;
            end
            ACT_RECORD: store_sample(now, ts, av, val);
            default:    query_window(now, r);
        endcase
        r.running = is_running(now);
        exp_mem[exp_wr] = r;
        exp_wr          = exp_wr + EXP_PTR_W'(1);
        exp_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_score_result e;
        if (!i_rst_n) begin
            win_len      = 32'd30000;
            age_cap      = 32'd15000;
            rate_start   = '0;
            rate_relaxed = '0;
            head         = '0;
            fill         = 0;
            sess_on      = 1'b0;
            sess_t0      = '0;
            exp_wr       = '0;
            exp_rd       = '0;
            exp_cnt      = 0;
            o_fail_count <= 0;
        end else begin
            // compare first, the transfer at this edge only appends
            if (i_done) begin
                if (exp_cnt == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer at %0t", $realtime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e      = exp_mem[exp_rd];
                    exp_rd = exp_rd + EXP_PTR_W'(1);
                    exp_cnt--;
                    if (e.running !== i_session_running || e.avail !== i_score_available ||
                        e.score !== i_score || e.cov !== i_coverage) begin
                        if (o_fail_count < 10)
                            $display({"mismatch at %0t: exp run %0b avail %0b score %0d ",
                                      "cov %0d, got run %0b avail %0b score %0d cov %0d"},
                                     $realtime, e.running, e.avail, e.score, e.cov,
                                     i_session_running, i_score_available, i_score,
                                     i_coverage);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LENGTH: win_len = i_cfg_data;
                    CFG_MAX_AGE:       age_cap = i_cfg_data;
                    CFG_REF_START: begin
                        rate_start = i_cfg_data[RATE_W-1:0];
                        head = '0;
                        fill = 0;
                    end
                    default: begin
                        rate_relaxed = i_cfg_data[RATE_W-1:0];
                        head = '0;
                        fill = 0;
                    end
                endcase
            end
            if (i_start && !i_busy)
                predict_window_result(t_action'(i_action), i_now, i_sample_time,
                                      i_sample_available, i_sample_value);
        end
    end

    assign o_pending = exp_cnt;

endmodule

`default_nettype wire

// ===== test/time_weighted_window_averager_test.sv =====
// ----------------------------------------------------------------------------
// time_weighted_window_averager_test
// drives sessions of start, stop, record and query commands through the
// averager under several register settings and sender idle patterns; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module time_weighted_window_averager_test;
    import twwa_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_action;
    logic [TIME_W-1:0]     i_now;
    logic [TIME_W-1:0]     i_sample_time;
    logic                  i_sample_available;
    logic [RATE_W-1:0]     i_sample_value;
    logic                  o_done;
    logic                  o_session_running;
    logic                  o_score_available;
    logic [FRAC_W-1:0]     o_score;
    logic [FRAC_W-1:0]     o_coverage;
    int                    fail_count;
    int                    pending;

    // chance in percent that the sender goes idle after a transfer
    int                    idle_pct;
    int                    quiet_cycles;
    logic [TIME_W-1:0]     clock_ms;

    time_weighted_window_averager dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_now              (i_now),
        .i_sample_time      (i_sample_time),
        .i_sample_available (i_sample_available),
        .i_sample_value     (i_sample_value),
        .o_done             (o_done),
        .o_session_running  (o_session_running),
        .o_score_available  (o_score_available),
        .o_score            (o_score),
        .o_coverage         (o_coverage)
    );

    twwa_score_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_start            (start),
        .i_busy             (busy),
        .i_action           (i_action),
        .i_now              (i_now),
        .i_sample_time      (i_sample_time),
        .i_sample_available (i_sample_available),
        .i_sample_value     (i_sample_value),
        .i_done             (o_done),
        .i_session_running  (o_session_running),
        .i_score_available  (o_score_available),
        .i_score            (o_score),
        .i_coverage         (o_coverage),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any transfer, result or register write resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command transfer; start stays high into the next command when no gap follows
    task automatic send_cmd(input t_action act, input logic [TIME_W-1:0] now,
                            input logic [TIME_W-1:0] ts, input logic av,
                            input logic [RATE_W-1:0] val);
        start              <= 1'b1;
        i_action           <= act;
        i_now              <= now;
        i_sample_time      <= ts;
        i_sample_available <= av;
        i_sample_value     <= val;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // block idle: all results back, then a short pause before any register write
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] win, input logic [31:0] age,
                            input logic [15:0] ref_hi, input logic [15:0] ref_lo);
        drain();
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_MAX_AGE, age);
        write_reg(CFG_REF_START, {16'h0, ref_hi});
        write_reg(CFG_REF_RELAXED, {16'h0, ref_lo});
    endtask

    // a session with random content; step sets the time scale of the phase
    task automatic random_session(input int items, input logic [31:0] step);
        int          r;
        logic [31:0] ts;
        logic [15:0] val;
        send_cmd(ACT_START, clock_ms, $urandom, 1'($urandom_range(1)), 16'($urandom));
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if ($urandom_range(19) == 0)
                clock_ms -= $urandom_range(0, step);
            else
                clock_ms += $urandom_range(0, step);
            if (r < 3) begin
                send_cmd(ACT_STOP, clock_ms, $urandom, 1'($urandom_range(1)), 16'($urandom));
            end else if (r < 6) begin
                send_cmd(ACT_START, clock_ms, $urandom, 1'($urandom_range(1)), 16'($urandom));
            end else if (r < 60) begin
                ts  = ($urandom_range(9) < 8) ? clock_ms - $urandom_range(0, step) : $urandom;
                val = ($urandom_range(19) == 0) ? 16'h0 :
                      ($urandom_range(1) != 0) ? 16'($urandom_range(16'h3000, 16'h6000)) :
                      16'($urandom);
                send_cmd(ACT_RECORD, clock_ms, ts, $urandom_range(9) != 0, val);
            end else begin
                send_cmd(ACT_QUERY, clock_ms, $urandom, 1'($urandom_range(1)), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        start              = 1'b0;
        i_action           = ACT_START;
        i_now              = '0;
        i_sample_time      = '0;
        i_sample_available = 1'b0;
        i_sample_value     = '0;
        idle_pct           = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 80 bpm start, 60 bpm relaxed, reset window and age
        set_regs(32'd30000, 32'd15000, 16'h5000, 16'h3C00);
        send_cmd(ACT_QUERY,  32'd100,   32'd0, 1'b0, 16'h0);        // no session
        send_cmd(ACT_RECORD, 32'd100,   32'd90, 1'b1, 16'h5000);    // not running
        send_cmd(ACT_START,  32'd1000,  32'd0, 1'b0, 16'h0);
        send_cmd(ACT_QUERY,  32'd1000,  32'd0, 1'b0, 16'h0);        // empty store
        send_cmd(ACT_RECORD, 32'd2000,  32'd1900, 1'b1, 16'h5000);
        send_cmd(ACT_RECORD, 32'd2000,  32'd1900, 1'b1, 16'h4000);  // not later
        send_cmd(ACT_RECORD, 32'd3000,  32'd3500, 1'b1, 16'h4800);  // stamped in the future
        send_cmd(ACT_RECORD, 32'd4000,  32'd500,  1'b1, 16'h4800);  // before session start
        send_cmd(ACT_RECORD, 32'd5000,  32'd4900, 1'b0, 16'h4800);  // unavailable
        send_cmd(ACT_RECORD, 32'd6000,  32'd5900, 1'b1, 16'h0);     // zero rate
        send_cmd(ACT_RECORD, 32'd20000, 32'd19990, 1'b1, 16'hFFFF);
        send_cmd(ACT_QUERY,  32'd19000, 32'd0, 1'b0, 16'h0);        // last sample after now
        send_cmd(ACT_QUERY,  32'd25000, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_RECORD, 32'd40000, 32'd39000, 1'b1, 16'h3C00);
        send_cmd(ACT_QUERY,  32'd45000, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_RECORD, 32'd60000, 32'd59999, 1'b1, 16'h5000); // prunes older samples
        send_cmd(ACT_QUERY,  32'd70000, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_QUERY,  32'hFFFFFFFF, 32'd0, 1'b0, 16'h0);     // last sample too old
        send_cmd(ACT_STOP,   32'd80000, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_QUERY,  32'd80001, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_START,  32'hFFFFFF00, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_RECORD, 32'hFFFFFFFF, 32'hFFFFFFF0, 1'b1, 16'h4000);
        send_cmd(ACT_QUERY,  32'hFFFFFFFF, 32'd0, 1'b0, 16'h0);
        send_cmd(ACT_RECORD, 32'd500, 32'd400, 1'b1, 16'h4000);     // now before session start

        // random phases, each with its own registers; the idle pattern repeats every four phases
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_regs(32'd30000, 32'd15000, 16'h5000, 16'h3C00);
                1: set_regs(32'd1000, 32'd400, 16'h5000, 16'h3C00);
                2: set_regs(32'd1, 32'd1, 16'h5000, 16'h3C00);
                3: set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'h0001);
                4: set_regs(32'd5000, 32'd3000, 16'hFFFF, 16'h0001);
                5: set_regs(32'd5000, 32'd3000, 16'd300, 16'd100);    // uncalibrated
                6: set_regs(32'd2000, 32'd100000, 16'h5000, 16'h3C00); // age cap above window length
                default: set_regs(32'd4000, 32'd2500, 16'hFFFF, 16'hFEFF); // one bpm apart
            endcase
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 77;
                2: idle_pct = 0;
                default: idle_pct = 10;
            endcase
            clock_ms = (p == 3) ? $urandom : 32'($urandom_range(0, 100000));
            for (int s = 0; s < 2; s++) begin
                case (p)
                    2: random_session(30, 32'd3);
                    3: random_session(30, 32'h0FFFFFFF);
                    6: random_session(30, 32'd20);
                    1: random_session(30, 32'd300);
                    default: random_session(30, 32'd2000);
                endcase
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
